[src/vrsp_pkg.sv]
// Shared types, codes and constants of the video register and scroll port.
`timescale 1ns / 1ps
`default_nettype none
package vrsp_pkg;

	localparam int SprDepth = 256;
	localparam int PalDepth = 32;
	localparam int SprAw    = $clog2(SprDepth);
	localparam int PalAw    = $clog2(PalDepth);

	typedef enum logic [3:0] {
		MODE_READ       = 4'd0,
		MODE_WRITE      = 4'd1,
		MODE_INC_X      = 4'd2,
		MODE_INC_Y      = 4'd3,
		MODE_COPY_HORIZ = 4'd4,
		MODE_COPY_VERT  = 4'd5,
		MODE_VBL_BEGIN  = 4'd6,
		MODE_VBL_END    = 4'd7,
		MODE_SET_FLAGS  = 4'd8
	} mode_t;

	localparam logic [2:0] REG_CTRL    = 3'd0;
	localparam logic [2:0] REG_MASK    = 3'd1;
	localparam logic [2:0] REG_STATUS  = 3'd2;
	localparam logic [2:0] REG_OAMADDR = 3'd3;
	localparam logic [2:0] REG_OAMDATA = 3'd4;
	localparam logic [2:0] REG_SCROLL  = 3'd5;
	localparam logic [2:0] REG_ADDR    = 3'd6;
	localparam logic [2:0] REG_DATA    = 3'd7;

	localparam logic [14:0] T_KEEP_NT     = 15'h73ff;
	localparam logic [14:0] T_KEEP_HI     = 15'h7fe0;
	localparam logic [14:0] T_KEEP_SCROLL = 15'h0c1f;
	localparam logic [14:0] T_KEEP_LO     = 15'h00ff;
	localparam logic [14:0] T_KEEP_TOP    = 15'h7f00;
	localparam logic [14:0] V_HORIZ_KEEP  = 15'h7be0;
	localparam logic [14:0] T_HORIZ_BITS  = 15'h041f;
	localparam logic [13:0] PAL_BASE_LAST = 14'h3eff;
	localparam logic [4:0]  PAL_MIRROR_MASK = 5'h13;
	localparam logic [4:0]  PAL_MIRROR_HIT  = 5'h10;
	localparam logic [7:0]  GRAY_MASK     = 8'h30;
	localparam logic [4:0]  COARSE_Y_LAST_ROW = 5'd29;

	typedef enum logic [1:0] {
		RD_ZERO    = 2'd0,
		RD_BYTE    = 2'd1,
		RD_SPRITE  = 2'd2,
		RD_PALETTE = 2'd3
	} rd_sel_t;

	// Memory requests issued at the accepting edge
	typedef struct packed {
		logic             spr_re;
		logic             spr_we;
		logic [SprAw-1:0] spr_addr;
		logic             pal_re;
		logic             pal_we;
		logic [PalAw-1:0] pal_addr;
		logic [7:0]       wdata;
	} mem_req_t;

	// Everything the result needs besides memory read data
	typedef struct packed {
		rd_sel_t     rd_sel;
		logic [7:0]  rd_byte;
		logic        gray;
		logic        ext_write;
		logic [7:0]  ext_write_data;
		logic [14:0] vram_address;
		logic [2:0]  fine_x;
		logic        nmi_line;
		logic [5:0]  control_bits;
		logic [7:0]  mask_bits;
	} stage_t;

	function automatic logic [PalAw-1:0] pal_index(input logic [13:0] a);
		logic [4:0] lo;
		lo = a[4:0];
		if ((lo & PAL_MIRROR_MASK) == PAL_MIRROR_HIT) begin
			lo = lo & ~PAL_MIRROR_HIT;
		end
		return lo;
	endfunction

endpackage
`default_nettype wire

[src/vrsp_ram.sv]
// Synchronous RAM with per-entry valid bits that read as zero until written.
`timescale 1ns / 1ps
`default_nettype none
module vrsp_ram #(
	parameter int Depth = 32,
	parameter int Width = 8
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     re,
	input  wire logic [$clog2(Depth)-1:0] raddr,
	input  wire logic                     we,
	input  wire logic [$clog2(Depth)-1:0] waddr,
	input  wire logic [Width-1:0]         wdata,
	output logic      [Width-1:0]         rdata
);

	logic [Width-1:0] mem [Depth];
	logic [Depth-1:0] vld_q;
	logic [Width-1:0] rd_q;
	logic             rvld_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rd_q <= mem[raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q  <= '0;
			rvld_q <= 1'b0;
		end else begin
			if (we) begin
				vld_q[waddr] <= 1'b1;
			end
			if (re) begin
				rvld_q <= vld_q[raddr];
			end
		end
	end

	assign rdata = rvld_q ? rd_q : '0;

endmodule
`default_nettype wire

[src/vrsp_ctrl.sv]
// Register file state, scroll address arithmetic and memory request decode.
`timescale 1ns / 1ps
`default_nettype none
module vrsp_ctrl import vrsp_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       accept,
	input  wire logic [3:0] mode,
	input  wire logic [2:0] reg_index,
	input  wire logic [7:0] cpu_data,
	input  wire logic [7:0] memory_data,
	input  wire logic       in_render_lines,
	output mem_req_t        req,
	output stage_t          stage
);

	logic [14:0] cur_q, cur_n;
	logic [14:0] tmp_q, tmp_n;
	logic [2:0]  fine_q, fine_n;
	logic        tog_q, tog_n;
	logic [7:0]  buf_q, buf_n;
	logic [7:0]  last_q, last_n;
	logic [7:0]  idx_q, idx_n;
	logic [5:0]  ctl_q, ctl_n;
	logic [7:0]  mask_q, mask_n;
	logic [2:0]  flags_q, flags_n;  // vblank, zero hit, overflow

	logic        drawing;
	logic        busy;
	logic        is_pal;
	logic [14:0] step;
	logic [14:0] tmp_w;
	logic [4:0]  coarse;

	always_comb begin
		cur_n   = cur_q;
		tmp_n   = tmp_q;
		fine_n  = fine_q;
		tog_n   = tog_q;
		buf_n   = buf_q;
		last_n  = last_q;
		idx_n   = idx_q;
		ctl_n   = ctl_q;
		mask_n  = mask_q;
		flags_n = flags_q;
		tmp_w   = tmp_q;
		coarse  = '0;

		drawing = mask_q[4] | mask_q[3];
		busy    = drawing & in_render_lines;
		is_pal  = cur_q[13:0] > PAL_BASE_LAST;
		step    = ctl_q[0] ? 15'd32 : 15'd1;

		req          = '0;
		req.spr_addr = idx_q;
		req.pal_addr = pal_index(cur_q[13:0]);
		req.wdata    = cpu_data;

		stage                = '0;
		stage.rd_sel         = RD_ZERO;
		stage.gray           = mask_q[0];

		case (mode)
			MODE_READ: begin
				unique case (reg_index)
					REG_STATUS: begin
						stage.rd_sel  = RD_BYTE;
						stage.rd_byte = {flags_q, last_q[4:0]};
						tog_n         = 1'b0;
						flags_n[2]    = 1'b0;
					end
					REG_OAMDATA: begin
						stage.rd_sel = RD_SPRITE;
						req.spr_re   = 1'b1;
					end
					REG_DATA: begin
						if (!busy) begin
							if (is_pal) begin
								stage.rd_sel = RD_PALETTE;
								req.pal_re   = 1'b1;
							end else begin
								stage.rd_sel  = RD_BYTE;
								stage.rd_byte = buf_q;
							end
							buf_n = memory_data;
							cur_n = cur_q + step;
						end
					end
					default: begin
					end
				endcase
			end
			MODE_WRITE: begin
				last_n = cpu_data;
				unique case (reg_index)
					REG_CTRL: begin
						ctl_n = cpu_data[7:2];
						tmp_n = (tmp_q & T_KEEP_NT) | {3'b0, cpu_data[1:0], 10'b0};
					end
					REG_MASK: mask_n = cpu_data;
					REG_OAMADDR: idx_n = cpu_data;
					REG_OAMDATA: begin
						req.spr_we = 1'b1;
						idx_n      = idx_q + 8'd1;
					end
					REG_SCROLL: begin
						if (!tog_q) begin
							fine_n = cpu_data[2:0];
							tmp_n  = (tmp_q & T_KEEP_HI) | {10'b0, cpu_data[7:3]};
						end else begin
							tmp_n = (tmp_q & T_KEEP_SCROLL) |
								{cpu_data[2:0], 2'b0, cpu_data[7:3], 5'b0};
						end
						tog_n = ~tog_q;
					end
					REG_ADDR: begin
						if (!tog_q) begin
							tmp_n = (tmp_q & T_KEEP_LO) | {1'b0, cpu_data[5:0], 8'b0};
						end else begin
							tmp_w = (tmp_q & T_KEEP_TOP) | {7'b0, cpu_data};
							tmp_n = tmp_w;
							cur_n = tmp_w;
						end
						tog_n = ~tog_q;
					end
					REG_DATA: begin
						if (!busy) begin
							if (is_pal) begin
								req.pal_we = 1'b1;
							end else begin
								stage.ext_write      = 1'b1;
								stage.ext_write_data = cpu_data;
							end
							cur_n = cur_q + step;
						end
					end
					default: begin
					end
				endcase
			end
			MODE_INC_X: begin
				if (drawing) begin
					cur_n[4:0] = cur_q[4:0] + 5'd1;
					if (cur_q[4:0] == 5'h1f) begin
						cur_n[10] = ~cur_q[10];
					end
				end
			end
			MODE_INC_Y: begin
				if (drawing) begin
					cur_n[14:12] = cur_q[14:12] + 3'd1;
					if (cur_q[14:12] == 3'd7) begin
						coarse = cur_q[9:5];
						if (coarse == COARSE_Y_LAST_ROW) begin
							cur_n[9:5] = '0;
							cur_n[11]  = ~cur_q[11];
						end else begin
							cur_n[9:5] = coarse + 5'd1;
						end
					end
				end
			end
			MODE_COPY_HORIZ: begin
				if (drawing) begin
					cur_n = (cur_q & V_HORIZ_KEEP) | (tmp_q & T_HORIZ_BITS);
				end
			end
			MODE_COPY_VERT: begin
				if (drawing) begin
					cur_n = (cur_q & T_HORIZ_BITS) | (tmp_q & V_HORIZ_KEEP);
				end
			end
			MODE_VBL_BEGIN: flags_n[2] = 1'b1;
			MODE_VBL_END: flags_n = '0;
			MODE_SET_FLAGS: flags_n[1:0] = flags_q[1:0] | {cpu_data[0], cpu_data[1]};
			default: begin
			end
		endcase

		stage.vram_address = cur_n;
		stage.fine_x       = fine_n;
		stage.nmi_line     = ctl_n[5] & flags_n[2];
		stage.control_bits = ctl_n;
		stage.mask_bits    = mask_n;

		if (!accept) begin
			req.spr_re = 1'b0;
			req.spr_we = 1'b0;
			req.pal_re = 1'b0;
			req.pal_we = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q   <= '0;
			tmp_q   <= '0;
			fine_q  <= '0;
			tog_q   <= 1'b0;
			buf_q   <= '0;
			last_q  <= '0;
			idx_q   <= '0;
			ctl_q   <= '0;
			mask_q  <= '0;
			flags_q <= '0;
		end else if (accept) begin
			cur_q   <= cur_n;
			tmp_q   <= tmp_n;
			fine_q  <= fine_n;
			tog_q   <= tog_n;
			buf_q   <= buf_n;
			last_q  <= last_n;
			idx_q   <= idx_n;
			ctl_q   <= ctl_n;
			mask_q  <= mask_n;
			flags_q <= flags_n;
		end
	end

endmodule
`default_nettype wire

[src/video_register_scroll_port.sv]
// Top level of the video register port and scroll-address unit.
// A result passes through stage one and then the output register after its transaction
// is accepted. One transaction per cycle while the input is not stalled; the sprite and
// palette memories are read at the accepting edge and their registered byte is picked in stage one.
// Reset: arst_n clears the state and valid registers and every memory valid bit at once, so both
// memories read as zero until written; no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none
module video_register_scroll_port import vrsp_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [3:0]  mode,
	input  wire logic [2:0]  reg_index,
	input  wire logic [7:0]  cpu_data,
	input  wire logic [7:0]  memory_data,
	input  wire logic        in_render_lines,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [7:0]       read_data,
	output logic [14:0]      vram_address,
	output logic [2:0]       fine_x,
	output logic             nmi_line,
	output logic             ext_write,
	output logic [7:0]       ext_write_data,
	output logic [5:0]       control_bits,
	output logic [7:0]       mask_bits
);

	mem_req_t   req;
	stage_t     stage;
	stage_t     stage_s1;
	logic       valid_s1;
	logic       out_valid_q;
	logic       out_free;
	logic       accept;
	logic [7:0] spr_rdata;
	logic [7:0] pal_rdata;
	logic [7:0] rd_s1;

	// Output register frees when empty or when its transaction leaves this edge
	assign out_free = !out_valid_q || !out_stall;
	// Hold the input only while stage one is full and cannot drain
	assign in_stall = valid_s1 && !out_free;
	assign accept   = in_valid && !in_stall;

	// State update and memory access decode; state advances at the accepting edge
	vrsp_ctrl u_ctrl (
		.clk             (clk),
		.arst_n          (arst_n),
		.accept          (accept),
		.mode            (mode),
		.reg_index       (reg_index),
		.cpu_data        (cpu_data),
		.memory_data     (memory_data),
		.in_render_lines (in_render_lines),
		.req             (req),
		.stage           (stage)
	);

	// Sprite attribute memory, addressed by the sprite RAM index
	vrsp_ram #(.Depth(SprDepth), .Width(8)) u_spr_ram (
		.clk    (clk),
		.arst_n (arst_n),
		.re     (req.spr_re),
		.raddr  (req.spr_addr),
		.we     (req.spr_we),
		.waddr  (req.spr_addr),
		.wdata  (req.wdata),
		.rdata  (spr_rdata)
	);

	// Palette memory, addressed through backdrop mirroring
	vrsp_ram #(.Depth(PalDepth), .Width(8)) u_pal_ram (
		.clk    (clk),
		.arst_n (arst_n),
		.re     (req.pal_re),
		.raddr  (req.pal_addr),
		.we     (req.pal_we),
		.waddr  (req.pal_addr),
		.wdata  (req.wdata),
		.rdata  (pal_rdata)
	);

	// Stage one: hold the decoded result while the memories deliver their byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (out_free) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			stage_s1 <= stage;
		end
	end

	// Pick the returned byte; grayscale keeps only the luma bits of a palette read
	always_comb begin
		case (stage_s1.rd_sel)
			RD_BYTE:    rd_s1 = stage_s1.rd_byte;
			RD_SPRITE:  rd_s1 = spr_rdata;
			RD_PALETTE: rd_s1 = stage_s1.gray ? (pal_rdata & GRAY_MASK) : pal_rdata;
			default:    rd_s1 = '0;
		endcase
	end

	// Output register: advance when free, hold while the consumer stalls
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && valid_s1) begin
			read_data      <= rd_s1;
			vram_address   <= stage_s1.vram_address;
			fine_x         <= stage_s1.fine_x;
			nmi_line       <= stage_s1.nmi_line;
			ext_write      <= stage_s1.ext_write;
			ext_write_data <= stage_s1.ext_write_data;
			control_bits   <= stage_s1.control_bits;
			mask_bits      <= stage_s1.mask_bits;
		end
	end

	assign out_valid = out_valid_q;

`ifndef SYNTHESIS
	// A stalled input always means stage one is occupied
	a_stall_needs_s1: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1)
		else $error("input stalled with stage one empty");

	// Stage one that cannot drain keeps its transaction
	a_s1_held: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !out_free) |=> valid_s1)
		else $error("stage one dropped a transaction");

	// A memory is never read and written in the same cycle by one transaction
	a_no_rw_clash: assert property (@(posedge clk) disable iff (!arst_n)
		!((req.spr_re && req.spr_we) || (req.pal_re && req.pal_we)))
		else $error("read and write issued together");

	// An external write never coincides with a palette write
	a_ext_vs_pal: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && stage.ext_write) |-> !req.pal_we)
		else $error("external and palette write together");
`endif

endmodule
`default_nettype wire
